// ===== hw/rtl/kpsa_pkg.sv =====
// kpsa_pkg: item types, key map and register indexes for keypad_scan_autorepeat.
// No dependencies.
`timescale 1ns / 1ps

package kpsa_pkg;

    localparam int KEY_COUNT = 15;

    typedef logic [3:0] key_num_t;

    typedef struct packed {
        logic [31:0] group0_word;
        logic [31:0] group1_word;
        logic [31:0] now_tick;
        logic        clear_repeat;
    } kpsa_in_t;

    typedef struct packed {
        key_num_t pressed_key;
        key_num_t clicked_key;
        key_num_t repeat_key;
    } kpsa_out_t;

    // Bit k set: key k reads group one, clear: group zero. Bit 0 unused.
    localparam logic [15:0] KEY_GROUP = 16'hFFF0;

    // Masks of keys 1..15; every mask lies in the low 16 bits of its word.
    localparam logic [15:1][15:0] KEY_MASK = {
        16'h8000, 16'h4000, 16'h2000, 16'h1000, 16'h0800,
        16'h0400, 16'h0200, 16'h0100, 16'h0080, 16'h0040,
        16'h0020, 16'h0010, 16'h0100, 16'h0200, 16'h0300
    };

    localparam logic       REG_INITIAL_DELAY = 1'b0;
    localparam logic       REG_REPEAT_DELAY  = 1'b1;

    localparam logic [15:0] INITIAL_DELAY_RESET = 16'd500;
    localparam logic [15:0] REPEAT_DELAY_RESET  = 16'd175;

endpackage

// ===== hw/rtl/keypad_scan_autorepeat.sv =====
// keypad_scan_autorepeat: key scan decode, click detect and typematic repeat.
// Depends on kpsa_pkg.
`timescale 1ns / 1ps
//
// Usage:
//   Scan channel s_*: one item per key scan carries both active-low raw key
//   words, the current millisecond tick and a flag that forgets the held key.
//   Result channel m_*: one item per scan with the first pressed key, the
//   first newly clicked key and the typematic repeat key (0 means none).
//   Config port: cfg_wr_en writes cfg_wdata to initial_delay (index 0) or
//   repeat_delay (index 1) at the clock edge; write only while idle.
// Timing:
//   An accepted item lands in the input register; when it advances, the decode,
//   the tick compare and the state update run and the result register loads,
//   raising m_valid. One item per cycle is sustained while m_ready is high;
//   the throughput is set by the single input-to-result stage.
// Reset (aresetn low, synchronous): both pipeline registers empty, previous
//   words all ones, no held key, delays back to 500 and 175 ticks.
// Stall: while m_ready is low a waiting result holds; the input register
//   holds one more item, then s_ready drops until the result is taken.

module keypad_scan_autorepeat
    import kpsa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  kpsa_in_t    s_data,

    output logic        m_valid,
    input  logic        m_ready,
    output kpsa_out_t   m_data,

    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);

    logic        in_valid_reg;
    kpsa_in_t    in_data_reg;
    logic        out_valid_reg;
    kpsa_out_t   out_data_reg;
    kpsa_out_t   out_data_next;

    logic [31:0] prev_g0_reg;
    logic [31:0] prev_g1_reg;
    key_num_t    held_key_reg;
    key_num_t    held_key_next;
    logic [31:0] last_tick_reg;
    logic [31:0] last_tick_next;
    logic        repeating_reg;
    logic        repeating_next;
    logic [15:0] init_delay_reg;
    logic [15:0] rep_delay_reg;

    logic        advance;
    logic [15:0] down_now;
    logic [15:0] down_prev;
    key_num_t    pressed;
    key_num_t    clicked;
    key_num_t    held_eff;
    logic [31:0] tick_diff;
    logic [15:0] delay_sel;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_comb begin
        down_now  = '0;
        down_prev = '0;
        for (int i = 1; i <= KEY_COUNT; i++) begin
            if (KEY_GROUP[i]) begin
                down_now[i]  = (in_data_reg.group1_word[15:0] & KEY_MASK[i]) == 16'h0;
                down_prev[i] = (prev_g1_reg[15:0] & KEY_MASK[i]) == 16'h0;
            end else begin
                down_now[i]  = (in_data_reg.group0_word[15:0] & KEY_MASK[i]) == 16'h0;
                down_prev[i] = (prev_g0_reg[15:0] & KEY_MASK[i]) == 16'h0;
            end
        end
    end

    always_comb begin
        pressed = '0;
        clicked = '0;
        for (int i = KEY_COUNT; i >= 1; i--) begin
            if (down_now[i]) begin
                pressed = key_num_t'(i);
            end
            if (down_now[i] && !down_prev[i]) begin
                clicked = key_num_t'(i);
            end
        end
    end

    assign held_eff  = in_data_reg.clear_repeat ? '0 : held_key_reg;
    assign tick_diff = in_data_reg.now_tick - last_tick_reg;
    assign delay_sel = repeating_reg ? rep_delay_reg : init_delay_reg;

    always_comb begin
        held_key_next  = held_eff;
        last_tick_next = last_tick_reg;
        repeating_next = repeating_reg;
        out_data_next.pressed_key = pressed;
        out_data_next.clicked_key = clicked;
        out_data_next.repeat_key  = '0;
        if (clicked != '0) begin
            held_key_next            = clicked;
            repeating_next           = 1'b0;
            last_tick_next           = in_data_reg.now_tick;
            out_data_next.repeat_key = clicked;
        end else if (held_eff != '0 && down_now[held_eff]) begin
            if (!tick_diff[31] && tick_diff > {16'h0, delay_sel}) begin
                repeating_next           = 1'b1;
                last_tick_next           = in_data_reg.now_tick;
                out_data_next.repeat_key = held_eff;
            end
        end else begin
            held_key_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            prev_g0_reg   <= '1;
            prev_g1_reg   <= '1;
            held_key_reg  <= '0;
            last_tick_reg <= '0;
            repeating_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                prev_g0_reg   <= in_data_reg.group0_word;
                prev_g1_reg   <= in_data_reg.group1_word;
                held_key_reg  <= held_key_next;
                last_tick_reg <= last_tick_next;
                repeating_reg <= repeating_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_delay_reg <= INITIAL_DELAY_RESET;
            rep_delay_reg  <= REPEAT_DELAY_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_INITIAL_DELAY: init_delay_reg <= cfg_wdata;
                REG_REPEAT_DELAY:  rep_delay_reg  <= cfg_wdata;
                default:           init_delay_reg <= init_delay_reg;
            endcase
        end
    end

    // A click is always reported as the repeat key.
    a_click_reported: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.clicked_key != '0 |-> m_data.repeat_key == m_data.clicked_key)
        else $error("click not reported as repeat key");

    // Any reported key is pressed, so the first pressed key is never above it.
    a_repeat_pressed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.repeat_key != '0 |->
            m_data.pressed_key != '0 && m_data.pressed_key <= m_data.repeat_key)
        else $error("repeat key reported while not pressed");

    // A held key left in state after a scan was pressed in that scan.
    a_held_pressed: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && held_key_next != '0 |-> down_now[held_key_next])
        else $error("held key kept while released");

    // A stalled input register keeps its item.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_data_reg))
        else $error("input register lost a stalled item");

    // Reset leaves both stages empty and no held key.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !in_valid_reg && !out_valid_reg && held_key_reg == '0)
        else $error("state not cleared by reset");

endmodule

// ===== dv/testbench.sv =====
// testbench: self-checking testbench for keypad_scan_autorepeat.
// It predicts pressed, clicked and typematic keys per scan and checks each result item in order.
// Depends on kpsa_pkg and keypad_scan_autorepeat.
`timescale 1ns / 1ps

module testbench;
    import kpsa_pkg::*;

    localparam int LIMIT_CYCLES = 100000;
    localparam int PHASE_ITEMS  = 190;

    class typematic_board;
        int unsigned init_delay;
        int unsigned rep_delay;
        logic [31:0] prev0;
        logic [31:0] prev1;
        key_num_t    held;
        logic [31:0] last_tick;
        bit          repeating;
        kpsa_out_t   pending[$];
        int          errors;

        function new();
            init_delay = 500;
            rep_delay  = 175;
            prev0      = '1;
            prev1      = '1;
            held       = '0;
            last_tick  = '0;
            repeating  = 1'b0;
            errors     = 0;
        endfunction

        static function logic [31:0] key_mask(int k);
            case (k)
                1:       return 32'h0000_0300;
                2:       return 32'h0000_0200;
                3:       return 32'h0000_0100;
                default: return 32'h0000_0001 << k;
            endcase
        endfunction

        static function bit is_down(logic [31:0] w0, logic [31:0] w1, int k);
            logic [31:0] w;
            w = (k >= 4) ? w1 : w0;
            return (w & key_mask(k)) == 32'h0;
        endfunction

        function void set_delay(logic idx, logic [15:0] val);
            if (idx == REG_INITIAL_DELAY) begin
                init_delay = 32'(val);
            end else begin
                rep_delay = 32'(val);
            end
        endfunction

        function void take_scan(kpsa_in_t s);
            kpsa_out_t   r;
            logic [31:0] d;
            logic [31:0] lim;
            int          k;
            r = '0;
            if (s.clear_repeat) begin
                held = '0;
            end
            for (k = 1; k <= KEY_COUNT; k++) begin
                if (is_down(s.group0_word, s.group1_word, k)) begin
                    if (r.pressed_key == 0) r.pressed_key = 4'(k);
                    if (!is_down(prev0, prev1, k) && r.clicked_key == 0) r.clicked_key = 4'(k);
                end
            end
            if (r.clicked_key != 0) begin
                held       = r.clicked_key;
                repeating  = 1'b0;
                last_tick  = s.now_tick;
                r.repeat_key = r.clicked_key;
            end else if (held != 0 && is_down(s.group0_word, s.group1_word, held)) begin
                d   = s.now_tick - last_tick;
                lim = repeating ? rep_delay : init_delay;
                if (!d[31] && d > lim) begin
                    repeating    = 1'b1;
                    last_tick    = s.now_tick;
                    r.repeat_key = held;
                end
            end else begin
                held = '0;
            end
            prev0 = s.group0_word;
            prev1 = s.group1_word;
            pending.push_back(r);
        endfunction

        function void check_report(kpsa_out_t got);
            kpsa_out_t want;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result item %h", $time, got);
                return;
            end
            want = pending.pop_front();
            if (got.pressed_key !== want.pressed_key) begin
                errors++;
                $display("%0t: pressed_key expected %0d actual %0d", $time,
                         want.pressed_key, got.pressed_key);
            end
            if (got.clicked_key !== want.clicked_key) begin
                errors++;
                $display("%0t: clicked_key expected %0d actual %0d", $time,
                         want.clicked_key, got.clicked_key);
            end
            if (got.repeat_key !== want.repeat_key) begin
                errors++;
                $display("%0t: repeat_key expected %0d actual %0d", $time,
                         want.repeat_key, got.repeat_key);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    kpsa_in_t    s_data;
    logic        m_valid;
    logic        m_ready;
    kpsa_out_t   m_data;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [15:0] cfg_wdata;

    typematic_board board;
    logic [31:0]    tick;
    int             sent;
    int             cycle_count;
    bit             gaps_on;
    bit             hold_req;
    int             hold_left;

    keypad_scan_autorepeat uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // the long hold starts once the sender is offering items again
    initial begin
        m_ready   = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req && s_valid === 1'b1) begin
                hold_req  = 1'b0;
                hold_left = 80;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready = 1'b0;
            end else begin
                m_ready = aresetn && (!gaps_on || $urandom_range(0, 99) >= 34);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            board.check_report(m_data);
        end
    end

    function automatic kpsa_in_t scan(logic [31:0] w0, logic [31:0] w1, logic [31:0] t,
                                      logic clr);
        kpsa_in_t s;
        s.group0_word  = w0;
        s.group1_word  = w1;
        s.now_tick     = t;
        s.clear_repeat = clr;
        return s;
    endfunction

    function automatic kpsa_in_t build_scan(logic [15:0] keys, logic [31:0] t, logic clr);
        kpsa_in_t s;
        int       k;
        s = scan($urandom, $urandom, t, clr);
        s.group0_word[9:8]  = 2'b11;
        s.group1_word[15:4] = '1;
        for (k = 1; k <= KEY_COUNT; k++) begin
            if (keys[k]) begin
                if (k >= 4) s.group1_word &= ~typematic_board::key_mask(k);
                else s.group0_word &= ~typematic_board::key_mask(k);
            end
        end
        return s;
    endfunction

    function automatic logic [31:0] tick_step();
        int unsigned span_long;
        int unsigned span_short;
        span_long  = board.init_delay + board.init_delay / 4 + 2;
        span_short = board.rep_delay / 2 + 2;
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, span_long);
        return $urandom_range(0, span_short);
    endfunction

    function automatic logic [15:0] one_key();
        return 16'h0001 << $urandom_range(1, KEY_COUNT);
    endfunction

    task automatic send_scan(input kpsa_in_t item);
        @(negedge aclk);
        while (gaps_on && $urandom_range(0, 99) < 34) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = item;
        do @(posedge aclk); while (s_ready !== 1'b1);
        board.take_scan(item);
        sent++;
    endtask

    task automatic stop_input();
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(posedge aclk);
        board.set_delay(idx, val);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic run_phase(input logic [15:0] init_val, input logic [15:0] rep_val);
        int          target;
        int          mode;
        int          len;
        int          i;
        logic [15:0] keys;
        target = sent + PHASE_ITEMS;
        stop_input();
        drain();
        write_reg(REG_INITIAL_DELAY, init_val);
        write_reg(REG_REPEAT_DELAY, rep_val);
        while (sent < target) begin
            mode = $urandom_range(0, 9);
            keys = one_key();
            if ($urandom_range(0, 3) == 0) keys |= one_key();
            if (mode <= 6) begin
                len = $urandom_range(1, 30);
                for (i = 0; i < len; i++) begin
                    if ($urandom_range(0, 9) == 0) keys |= one_key();
                    tick += tick_step();
                    send_scan(build_scan(keys, tick, $urandom_range(0, 24) == 0));
                end
                tick += tick_step();
                send_scan(build_scan('0, tick, 1'b0));
            end else if (mode == 7) begin
                len = $urandom_range(1, 4);
                for (i = 0; i < len; i++) begin
                    tick = ($urandom_range(0, 1) == 0) ? tick + tick_step() : $urandom;
                    send_scan(scan($urandom, $urandom, tick, 1'($urandom_range(0, 1))));
                end
            end else if (mode == 8) begin
                len = $urandom_range(3, 12);
                for (i = 0; i < len; i++) begin
                    case ($urandom_range(0, 3))
                        0, 1:    tick -= $urandom_range(1, 2000);
                        2:       tick = $urandom;
                        default: tick += tick_step();
                    endcase
                    send_scan(build_scan(keys, tick, 1'b0));
                end
            end else begin
                len = $urandom_range(2, 8);
                for (i = 0; i < len; i++) begin
                    tick += tick_step();
                    send_scan(build_scan(i[0] ? 16'h0000 : keys, tick, 1'b0));
                end
            end
        end
    endtask

    initial begin
        int k;
        board       = new();
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_wr_en   = 1'b0;
        cfg_index   = REG_INITIAL_DELAY;
        cfg_wdata   = '0;
        sent        = 0;
        cycle_count = 0;
        gaps_on     = 1'b1;
        hold_req    = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset delays: click, initial delay edge, repeat delay edge, tick going back, clear
        send_scan(scan('1, '1, 32'd0, 1'b0));
        send_scan(scan('0, '0, 32'd10, 1'b0));
        send_scan(scan('0, '0, 32'd400, 1'b0));
        send_scan(scan('0, '0, 32'd510, 1'b0));
        send_scan(scan('0, '0, 32'd511, 1'b0));
        send_scan(scan('0, '0, 32'd686, 1'b0));
        send_scan(scan('0, '0, 32'd687, 1'b0));
        send_scan(scan('0, '0, 32'd100, 1'b0));
        send_scan(scan('0, '0, 32'd900, 1'b1));
        send_scan(scan('1, '1, 32'd1000, 1'b0));
        send_scan(scan('1, ~32'h0000_8000, 32'd1001, 1'b1));
        send_scan(scan(32'h0000_0300, 32'h0000_FFF0, 32'd1002, 1'b0));
        tick = 32'd1010;
        for (k = 1; k <= KEY_COUNT; k++) begin
            tick += 32'd3;
            send_scan(build_scan(16'h0001 << k, tick, 1'b0));
        end

        run_phase(16'd1, 16'd1);
        gaps_on = 1'b0;
        run_phase(16'hFFFF, 16'hFFFF);
        gaps_on = 1'b1;
        tick = 32'hFFFF_FF00;
        hold_req = 1'b1;
        run_phase(16'($urandom_range(2, 40)), 16'($urandom_range(1, 20)));
        run_phase(16'd0, 16'd0);
        run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));

        stop_input();
        drain();
        repeat (8) @(posedge aclk);
        if (board.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
